[hdl/spr_pkg.sv]
// shared types, command codes and register defaults for the stepper pulse ramp positioner
// no dependencies
`timescale 1ns / 1ps

package spr_pkg;

    // command codes carried in the input tuser field
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_STOP     = 3'd1;
    localparam logic [2:0] CMD_RUN      = 3'd2;
    localparam logic [2:0] CMD_HOME     = 3'd3;
    localparam logic [2:0] CMD_PUSH     = 3'd4;
    localparam logic [2:0] CMD_GOTO     = 3'd5;
    localparam logic [2:0] CMD_LOAD_POS = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_POSITION  = 2'd0;
    localparam logic [1:0] CFG_START_DELAY   = 2'd1;
    localparam logic [1:0] CFG_RAMP_INTERVAL = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] MAX_POSITION_RST  = 16'd65535;
    localparam logic [7:0]  START_DELAY_RST   = 8'd30;
    localparam logic [3:0]  RAMP_INTERVAL_RST = 4'd10;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic [2:0]  command;
        logic        run_direction;
        logic [15:0] target_position;
        logic        zero_switch;
    } t_item;

    typedef struct packed {
        logic        step_level;
        logic        dir_level;
        logic [15:0] position_now;
        logic        motor_running;
        logic        save_request;
        logic        push_done;
        logic        report_request;
    } t_result;

endpackage

[hdl/stepper_pulse_ramp_positioner_core.sv]
// top level of the stepper pulse ramp positioner
// depends on spr_pkg, spr_in_stage, spr_engine, spr_out_stage
`timescale 1ns / 1ps

// usage
//   slave stream: one transfer per tick or command; tuser is the command code,
//   tdata carries the run direction, the target or load value and the zero switch.
//   master stream: one result transfer per input transfer, in order, with the
//   step and direction levels, the position, the running flag and the
//   save / push done / report flags raised by that item.
//   config port: write enable, register index, data; write only while idle.
// path: an input transfer is captured in the input register, then the single-pass
//   update writes its result into the result register, which the master side offers.
// throughput: one item per cycle while not stalled; the whole state update for an
//   item is one pass of compare and increment logic between the two registers.
// reset: clears the motor state to stopped at position zero and loads the
//   default limit 65535, start delay 30 and ramp interval 10; both stages empty.
// stall: while the master side holds tready low the result stays in place; the
//   input register takes at most one more item, then tready on the slave side drops.
module stepper_pulse_ramp_positioner_core
    import spr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [0] run_direction, [16:1] target_position, [17] zero_switch, rest zero
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // [2:0] command
    input  logic [S_TUSER_W-1:0]  i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] step_level, [1] dir_level, [17:2] position_now, [18] motor_running,
    // [19] save_request, [20] push_done, [21] report_request, rest zero
    output logic [M_TDATA_W-1:0]  o_m_tdata
);

    logic    advance;
    logic    item_valid;
    t_item   item;
    t_result result;

    spr_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_advance  (advance),
        .o_valid    (item_valid),
        .o_item     (item)
    );

    spr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (advance),
        .i_item      (item),
        .o_result    (result)
    );

    spr_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (item_valid),
        .i_result   (result),
        .o_advance  (advance),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

[hdl/spr_in_stage.sv]
// input register stage: captures one command or tick per transfer
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_in_stage
    import spr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_advance,
    output logic                 o_valid,
    output t_item                o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_s_tready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.command         <= i_s_tuser;
            r_item.run_direction   <= i_s_tdata[0];
            r_item.target_position <= i_s_tdata[16:1];
            r_item.zero_switch     <= i_s_tdata[17];
        end
    end

endmodule

[hdl/spr_engine.sv]
// motor state, configuration registers and the single-pass next-state logic
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_engine
    import spr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_advance,
    input  t_item                 i_item,
    output t_result               o_result
);

    logic [15:0] r_max_position;
    logic [7:0]  r_start_delay;
    logic [3:0]  r_ramp_interval;

    logic        r_running,  n_running;
    logic        r_dir,      n_dir;
    logic        r_pulse,    n_pulse;
    logic [15:0] r_pos,      n_pos;
    logic [15:0] r_target,   n_target;
    logic        r_armed,    n_armed;
    logic [7:0]  r_half,     n_half;
    logic [7:0]  r_dcount,   n_dcount;
    logic [3:0]  r_rcount,   n_rcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_position  <= MAX_POSITION_RST;
            r_start_delay   <= START_DELAY_RST;
            r_ramp_interval <= RAMP_INTERVAL_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAX_POSITION:  r_max_position  <= i_cfg_wdata;
                CFG_START_DELAY:   r_start_delay   <= i_cfg_wdata[7:0];
                CFG_RAMP_INTERVAL: r_ramp_interval <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic save;
        logic pushed;
        logic report;
        n_running = r_running;
        n_dir     = r_dir;
        n_pulse   = r_pulse;
        n_pos     = r_pos;
        n_target  = r_target;
        n_armed   = r_armed;
        n_half    = r_half;
        n_dcount  = r_dcount;
        n_rcount  = r_rcount;
        save      = 1'b0;
        pushed    = 1'b0;
        report    = 1'b0;
        case (i_item.command)
            CMD_TICK: begin
                if (r_running && r_dir && !i_item.zero_switch) begin
                    // homing stop at the zero switch
                    n_running = 1'b0;
                    n_pos     = '0;
                    save      = 1'b1;
                end else if (r_running) begin
                    if (r_dcount < r_half) begin
                        n_dcount = r_dcount + 8'd1;
                    end else begin
                        n_dcount = '0;
                        if (!r_pulse) begin
                            n_pulse = 1'b1;
                        end else begin
                            // falling half-step moves the position
                            n_pulse = 1'b0;
                            if (!r_dir) begin
                                if (r_pos < r_max_position) begin
                                    n_pos = r_pos + 16'd1;
                                end else begin
                                    n_running = 1'b0;
                                    save      = 1'b1;
                                    pushed    = 1'b1;
                                end
                            end else if (r_pos != '0) begin
                                n_pos = r_pos - 16'd1;
                            end
                            if (r_armed && r_target == n_pos) begin
                                n_armed   = 1'b0;
                                n_running = 1'b0;
                                save      = 1'b1;
                            end
                        end
                        if (r_rcount < r_ramp_interval) begin
                            n_rcount = r_rcount + 4'd1;
                        end else begin
                            n_rcount = '0;
                            if (r_half > 8'd1) begin
                                n_half = r_half - 8'd1;
                            end
                        end
                    end
                end
            end
            CMD_STOP: begin
                n_running = 1'b0;
                save      = 1'b1;
                report    = 1'b1;
            end
            CMD_RUN: begin
                n_dir     = i_item.run_direction;
                n_half    = r_start_delay;
                n_running = 1'b1;
            end
            CMD_HOME: begin
                n_dir     = 1'b1;
                n_half    = r_start_delay;
                n_running = 1'b1;
            end
            CMD_PUSH: begin
                n_dir     = 1'b0;
                n_half    = r_start_delay;
                n_running = 1'b1;
            end
            CMD_GOTO: begin
                if (i_item.target_position <= r_max_position &&
                    i_item.target_position != r_pos) begin
                    n_target  = i_item.target_position;
                    n_armed   = 1'b1;
                    n_dir     = !(i_item.target_position > r_pos);
                    n_half    = r_start_delay;
                    n_running = 1'b1;
                end
            end
            CMD_LOAD_POS: begin
                n_pos = i_item.target_position;
            end
            default: ;
        endcase
        o_result.step_level     = n_pulse;
        o_result.dir_level      = n_dir;
        o_result.position_now   = n_pos;
        o_result.motor_running  = n_running;
        o_result.save_request   = save;
        o_result.push_done      = pushed;
        o_result.report_request = report;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_dir     <= 1'b0;
            r_pulse   <= 1'b0;
            r_pos     <= '0;
            r_target  <= '0;
            r_armed   <= 1'b0;
            r_half    <= '0;
            r_dcount  <= '0;
            r_rcount  <= '0;
        end else if (i_advance) begin
            r_running <= n_running;
            r_dir     <= n_dir;
            r_pulse   <= n_pulse;
            r_pos     <= n_pos;
            r_target  <= n_target;
            r_armed   <= n_armed;
            r_half    <= n_half;
            r_dcount  <= n_dcount;
            r_rcount  <= n_rcount;
        end
    end

endmodule

[hdl/spr_out_stage.sv]
// result register: holds one result until the master side takes it
// depends on spr_pkg
`timescale 1ns / 1ps

module spr_out_stage
    import spr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  t_result              i_result,
    output logic                 o_advance,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    logic    r_valid;
    t_result r_result;

    // a new result moves in when the slot is empty or is being drained
    assign o_advance  = i_in_valid && (!r_valid || i_m_tready);
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {2'b00,
                         r_result.report_request,
                         r_result.push_done,
                         r_result.save_request,
                         r_result.motor_running,
                         r_result.position_now,
                         r_result.dir_level,
                         r_result.step_level};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

endmodule
